@@ hw/rtl/blpe_pkg.sv @@
// Shared constants, codes and control types for the bounded list block.
package blpe_pkg;

  // List size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the ports
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int EIDX_W   = 4;
  localparam int ECNT_W   = 5;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR     = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_APPEND    = 3'd3,
    REQ_DEL_FRONT = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_DEL_END   = 3'd6,
    REQ_NONE      = 3'd7
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        at;        // edit position
    logic [IDX_W-1:0]        last;      // last occupied cell, for rotation
    logic signed [VAL_W-1:0] ins_value;
  } cell_ctl_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

@@ hw/rtl/blpe_cell.sv @@
// One storage cell of the list chain: holds one entry, trades with its neighbors.
module blpe_cell (
  input  logic                              clk,
  input  blpe_pkg::cell_ctl_t               ctl,
  input  logic [blpe_pkg::IDX_W-1:0]        my_idx,
  input  logic signed [blpe_pkg::VAL_W-1:0] prev_data,
  input  logic signed [blpe_pkg::VAL_W-1:0] next_data,
  input  logic signed [blpe_pkg::VAL_W-1:0] head_data,
  output logic signed [blpe_pkg::VAL_W-1:0] data
);

  logic signed [blpe_pkg::VAL_W-1:0] data_next;

  // Select the new entry from the broadcast operation and this cell's place
  always_comb begin
    data_next = data;
    case (ctl.op)
      blpe_pkg::CELL_INSERT: begin
        if (my_idx > ctl.at) begin
          data_next = prev_data;
        end else if (my_idx == ctl.at) begin
          data_next = ctl.ins_value;
        end
      end
      blpe_pkg::CELL_DELETE: begin
        if (my_idx >= ctl.at) begin
          data_next = next_data;
        end
      end
      blpe_pkg::CELL_ROTATE: begin
        // occupied cells move one toward the head, head wraps to the tail
        if (my_idx == ctl.last) begin
          data_next = head_data;
        end else if (my_idx < ctl.last) begin
          data_next = next_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry register, no reset: never read before written
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hw/rtl/bounded_list_positional_edit.sv @@
// Top level: request decode, list chain and result sequencing.
//
// channel | direction | beat carries
// req     | in        | req_type, position, value
// rsp     | out       | has_element, element, element_index, element_count, status, is_last
//
// A request beat is taken while idle; the edit (shift of the cell chain) happens on that edge.
// The list then streams out from the head cell, one beat per element (one beat when empty),
// rotating the chain once per beat as each beat is taken.
// The next request is taken only after the last result beat has gone.
// Reset (rst, synchronous) empties the list; entries themselves are not cleared.
// A stalled rsp beat holds: the chain does not move until the beat is taken.
module bounded_list_positional_edit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [blpe_pkg::REQ_W-1:0]         req_type,
  input  logic [blpe_pkg::POS_W-1:0]         position,
  input  logic signed [blpe_pkg::VAL_W-1:0]  value,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               has_element,
  output logic signed [blpe_pkg::VAL_W-1:0]  element,
  output logic [blpe_pkg::EIDX_W-1:0]        element_index,
  output logic [blpe_pkg::ECNT_W-1:0]        element_count,
  output logic [blpe_pkg::STAT_W-1:0]        status,
  output logic                               is_last
);

  blpe_pkg::state_t             state, state_next;
  logic [blpe_pkg::CNT_W-1:0]   fill_count, fill_count_next;
  logic [blpe_pkg::IDX_W-1:0]   cnt, cnt_next;
  blpe_pkg::status_t            stat, stat_next;
  blpe_pkg::cell_ctl_t          ctl;
  logic                         req_take;
  logic                         rsp_take;
  logic                         empty;
  logic                         full;
  logic                         pos_ok;
  logic                         last_beat;
  logic signed [blpe_pkg::VAL_W-1:0] cell_data [blpe_pkg::CAPACITY];

  assign req_take  = req_valid && req_ready;
  assign rsp_take  = rsp_valid && rsp_ready;
  assign empty     = (fill_count == '0);
  assign full      = (fill_count == blpe_pkg::CNT_W'(blpe_pkg::CAPACITY));
  assign pos_ok    = (position != '0) &&
                     (blpe_pkg::CMP_W'(position) <= blpe_pkg::CMP_W'(fill_count));
  assign last_beat = empty ||
                     (blpe_pkg::CNT_W'(cnt) + blpe_pkg::CNT_W'(1) == fill_count);

  // Cell chain
  for (genvar g = 0; g < blpe_pkg::CAPACITY; g++) begin : g_cell
    logic signed [blpe_pkg::VAL_W-1:0] prev_d;
    logic signed [blpe_pkg::VAL_W-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_p
      assign prev_d = cell_data[g-1];
    end
    if (g == blpe_pkg::CAPACITY - 1) begin : g_end
      assign next_d = '0;
    end else begin : g_mid_n
      assign next_d = cell_data[g+1];
    end
    blpe_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .my_idx    (blpe_pkg::IDX_W'(g)),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[g])
    );
  end

  // Request decode, chain control and sequencing
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    cnt_next        = cnt;
    stat_next       = stat;
    ctl.op          = blpe_pkg::CELL_HOLD;
    ctl.at          = '0;
    ctl.last        = blpe_pkg::IDX_W'(fill_count - blpe_pkg::CNT_W'(1));
    ctl.ins_value   = value;

    case (state)
      blpe_pkg::S_IDLE: begin
        if (req_take) begin
          state_next = blpe_pkg::S_LIST;
          cnt_next   = '0;
          stat_next  = blpe_pkg::ST_OK;
          case (blpe_pkg::req_t'(req_type))
            blpe_pkg::REQ_CLEAR: begin
              fill_count_next = '0;
            end
            blpe_pkg::REQ_INS_FRONT, blpe_pkg::REQ_APPEND: begin
              if (full) begin
                stat_next = blpe_pkg::ST_FULL;
              end else begin
                ctl.op          = blpe_pkg::CELL_INSERT;
                ctl.at          = (req_type == blpe_pkg::REQ_APPEND) ?
                                  blpe_pkg::IDX_W'(fill_count) : '0;
                fill_count_next = fill_count + blpe_pkg::CNT_W'(1);
              end
            end
            blpe_pkg::REQ_INS_AFTER: begin
              if (!pos_ok) begin
                stat_next = blpe_pkg::ST_BAD_POS;
              end else if (full) begin
                stat_next = blpe_pkg::ST_FULL;
              end else begin
                ctl.op          = blpe_pkg::CELL_INSERT;
                ctl.at          = blpe_pkg::IDX_W'(position);
                fill_count_next = fill_count + blpe_pkg::CNT_W'(1);
              end
            end
            blpe_pkg::REQ_DEL_FRONT, blpe_pkg::REQ_DEL_END: begin
              if (empty) begin
                stat_next = blpe_pkg::ST_EMPTY;
              end else begin
                ctl.op          = blpe_pkg::CELL_DELETE;
                ctl.at          = (req_type == blpe_pkg::REQ_DEL_END) ?
                                  blpe_pkg::IDX_W'(fill_count - blpe_pkg::CNT_W'(1)) : '0;
                fill_count_next = fill_count - blpe_pkg::CNT_W'(1);
              end
            end
            blpe_pkg::REQ_DEL_AT: begin
              if (empty) begin
                stat_next = blpe_pkg::ST_EMPTY;
              end else if (!pos_ok) begin
                stat_next = blpe_pkg::ST_BAD_POS;
              end else begin
                ctl.op          = blpe_pkg::CELL_DELETE;
                ctl.at          = blpe_pkg::IDX_W'(position - blpe_pkg::POS_W'(1));
                fill_count_next = fill_count - blpe_pkg::CNT_W'(1);
              end
            end
            default: begin
              stat_next = blpe_pkg::ST_OK;
            end
          endcase
        end
      end
      blpe_pkg::S_LIST: begin
        if (rsp_take) begin
          // rotate the next entry into the head cell
          if (!empty) begin
            ctl.op = blpe_pkg::CELL_ROTATE;
          end
          cnt_next = cnt + blpe_pkg::IDX_W'(1);
          if (last_beat) begin
            state_next = blpe_pkg::S_IDLE;
            cnt_next   = '0;
          end
        end
      end
      default: begin
        state_next = blpe_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= blpe_pkg::S_IDLE;
      fill_count <= '0;
      cnt        <= '0;
      stat       <= blpe_pkg::ST_OK;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      cnt        <= cnt_next;
      stat       <= stat_next;
    end
  end

  // Result beat comes straight from the head cell and counters
  assign req_ready     = (state == blpe_pkg::S_IDLE);
  assign rsp_valid     = (state == blpe_pkg::S_LIST);
  assign has_element   = !empty;
  assign element       = empty ? '0 : cell_data[0];
  assign element_index = blpe_pkg::EIDX_W'(cnt);
  assign element_count = blpe_pkg::ECNT_W'(fill_count);
  assign status        = stat;
  assign is_last       = last_beat;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= blpe_pkg::CNT_W'(blpe_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_cnt_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == blpe_pkg::S_LIST) && !empty |-> (blpe_pkg::CNT_W'(cnt) < fill_count))
    else $error("beat index past end of list");

  a_error_no_edit: assert property (@(posedge clk) disable iff (rst)
    req_take && (stat_next != blpe_pkg::ST_OK) |=> (fill_count == $past(fill_count)))
    else $error("rejected request changed the list");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    rsp_take && is_last |=> req_ready)
    else $error("not ready after last result beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(cnt) && $stable(fill_count))
    else $error("list moved during a stalled beat");

endmodule
